[src/point_to_segment_nearest_vector_core_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the point to segment nearest vector core
// Both macros sample on clk and are disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef POINT_TO_SEGMENT_NEAREST_VECTOR_CORE_DEFINES_SVH
`define POINT_TO_SEGMENT_NEAREST_VECTOR_CORE_DEFINES_SVH

// Check a consequence in the same cycle as its cause.
`define PTSN_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequence in the cycle after its cause.
`define PTSN_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/ptsn_pkg.sv]
// ----------------------------------------------------------------------------
// ptsn_pkg
// Widths, codes, item types and helpers shared by the nearest vector core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptsn_pkg;

	// coordinate width, signed Q16.16
	localparam int CB  = 32;
	// coordinate differences
	localparam int DW  = CB + 1;
	// signed products of two differences
	localparam int PW  = 2 * DW - 1;
	// signed dot product
	localparam int SW  = PW + 1;
	// unsigned squared length and interior numerator
	localparam int NW  = 2 * CB + 1;
	// high part of the numerator split
	localparam int HIW = NW - CB;
	// dividend width, numerator times one component magnitude
	localparam int RW  = NW + CB;
	// quotient bits
	localparam int QB  = CB;
	// offset before saturation
	localparam int EW  = DW + 1;
	// queue depth and pointer width
	localparam int QD  = 4;
	localparam int QAW = 2;

	// configuration register indexes
	localparam logic [1:0] REG_P_X = 2'd0;
	localparam logic [1:0] REG_P_Y = 2'd1;
	localparam logic [1:0] REG_Q_X = 2'd2;
	localparam logic [1:0] REG_Q_Y = 2'd3;

	typedef enum logic [1:0] {
		CASE_P   = 2'd0,
		CASE_Q   = 2'd1,
		CASE_MID = 2'd2
	} case_t;

	// classified item handed from front to back
	typedef struct packed {
		case_t                 cs;
		logic signed [DW-1:0]  bx;
		logic signed [DW-1:0]  by;
		logic [NW-1:0]         num;
		logic [NW-1:0]         den;
		logic [CB-1:0]         mx;
		logic [CB-1:0]         my;
		logic                  sx;
		logic                  sy;
	} back_item_t;

	// divider stage contents, one lane per component
	typedef struct packed {
		case_t                 cs;
		logic signed [DW-1:0]  bx;
		logic signed [DW-1:0]  by;
		logic [NW-1:0]         den;
		logic                  sx;
		logic                  sy;
		logic [RW-1:0]         rx;
		logic [RW-1:0]         ry;
		logic [QB-1:0]         qx;
		logic [QB-1:0]         qy;
	} div_t;

	// finished result
	typedef struct packed {
		logic signed [CB-1:0]  ex;
		logic signed [CB-1:0]  ey;
		case_t                 cs;
	} out_item_t;

	// clamp to the signed coordinate range
	function automatic logic signed [CB-1:0] sat_coord(input logic signed [EW-1:0] v);
		logic signed [CB-1:0] r;
		if (v[EW-1:CB-1] == '0 || v[EW-1:CB-1] == '1) begin
			r = v[CB-1:0];
		end else if (v[EW-1]) begin
			r = {1'b1, {(CB-1){1'b0}}};
		end else begin
			r = {1'b0, {(CB-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

[src/ptsn_queue.sv]
// ----------------------------------------------------------------------------
// ptsn_queue
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptsn_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr,
	input  ptsn_pkg::back_item_t   wr_item,
	output logic                   full,
	input  logic                   rd,
	output ptsn_pkg::back_item_t   head,
	output logic                   empty
);

	ptsn_pkg::back_item_t mem_q [ptsn_pkg::QD];
	logic [ptsn_pkg::QAW-1:0] wp_q, rp_q;
	logic [ptsn_pkg::QAW:0]   cnt_q;
	logic wr_acc, rd_acc;

	assign full   = (cnt_q == (ptsn_pkg::QAW + 1)'(ptsn_pkg::QD));
	assign empty  = (cnt_q == '0);
	assign wr_acc = wr && !full;
	assign rd_acc = rd && !empty;
	assign head   = mem_q[rp_q];

	// store item
	always_ff @(posedge clk) begin
		if (wr_acc) begin
			mem_q[wp_q] <= wr_item;
		end
	end

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_acc) begin
				wp_q <= wp_q + 1'b1;
			end
			if (rd_acc) begin
				rp_q <= rp_q + 1'b1;
			end
			if (wr_acc && !rd_acc) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_acc && !wr_acc) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[src/ptsn_front.sv]
// ----------------------------------------------------------------------------
// ptsn_front
// Accepts query points, forms the projection terms and classifies each item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptsn_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic signed [ptsn_pkg::CB-1:0]    p_x,
	input  logic signed [ptsn_pkg::CB-1:0]    p_y,
	input  logic signed [ptsn_pkg::CB-1:0]    q_x,
	input  logic signed [ptsn_pkg::CB-1:0]    q_y,
	input  logic                              push,
	input  logic signed [ptsn_pkg::CB-1:0]    x,
	input  logic signed [ptsn_pkg::CB-1:0]    y,
	output logic                              full,
	output logic                              item_valid,
	output ptsn_pkg::back_item_t              item,
	input  logic                              item_full
);

	localparam int DW = ptsn_pkg::DW;
	localparam int PW = ptsn_pkg::PW;
	localparam int SW = ptsn_pkg::SW;
	localparam int NW = ptsn_pkg::NW;
	localparam int CB = ptsn_pkg::CB;

	logic en;
	logic v_s1, v_s2, v_s3;
	logic signed [DW-1:0] dx_s1, dy_s1, wx_s1, wy_s1, eqx_s1, eqy_s1;
	logic signed [DW-1:0] dx_s2, dy_s2, wx_s2, wy_s2, eqx_s2, eqy_s2;
	logic signed [PW-1:0] pwx_s2, pwy_s2, pdx_s2, pdy_s2;
	logic signed [DW-1:0] dx_s3, dy_s3, wx_s3, wy_s3, eqx_s3, eqy_s3;
	logic signed [SW-1:0] num_s3;
	logic [NW-1:0]        den_s3;
	logic signed [SW-1:0] den_sum;
	logic num_pos, den_nz, num_ge;

	// stall the whole front when the last stage cannot hand off
	assign en   = !(v_s3 && item_full);
	assign full = !en;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= push;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// stage 1: differences against the segment ends
	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1  <= DW'(q_x) - DW'(p_x);
			dy_s1  <= DW'(q_y) - DW'(p_y);
			wx_s1  <= DW'(x) - DW'(p_x);
			wy_s1  <= DW'(y) - DW'(p_y);
			eqx_s1 <= DW'(q_x) - DW'(x);
			eqy_s1 <= DW'(q_y) - DW'(y);
		end
	end

	// stage 2: products for the dot product and the squared length
	always_ff @(posedge clk) begin
		if (en) begin
			pwx_s2 <= wx_s1 * dx_s1;
			pwy_s2 <= wy_s1 * dy_s1;
			pdx_s2 <= dx_s1 * dx_s1;
			pdy_s2 <= dy_s1 * dy_s1;
			dx_s2  <= dx_s1;
			dy_s2  <= dy_s1;
			wx_s2  <= wx_s1;
			wy_s2  <= wy_s1;
			eqx_s2 <= eqx_s1;
			eqy_s2 <= eqy_s1;
		end
	end

	assign den_sum = SW'(pdx_s2) + SW'(pdy_s2);

	// stage 3: numerator and squared length
	always_ff @(posedge clk) begin
		if (en) begin
			num_s3 <= SW'(pwx_s2) + SW'(pwy_s2);
			den_s3 <= den_sum[NW-1:0];
			dx_s3  <= dx_s2;
			dy_s3  <= dy_s2;
			wx_s3  <= wx_s2;
			wy_s3  <= wy_s2;
			eqx_s3 <= eqx_s2;
			eqy_s3 <= eqy_s2;
		end
	end

	// classify and build the item for the back
	assign num_pos = !num_s3[SW-1] && (num_s3 != '0);
	assign den_nz  = (den_s3 != '0);
	assign num_ge  = (num_s3 >= $signed({1'b0, den_s3}));

	always_comb begin
		item.num = num_s3[NW-1:0];
		item.den = den_s3;
		item.mx  = dx_s3[DW-1] ? CB'(-dx_s3) : dx_s3[CB-1:0];
		item.my  = dy_s3[DW-1] ? CB'(-dy_s3) : dy_s3[CB-1:0];
		item.sx  = dx_s3[DW-1];
		item.sy  = dy_s3[DW-1];
		if (!(den_nz && num_pos)) begin
			item.cs = ptsn_pkg::CASE_P;
			item.bx = -wx_s3;
			item.by = -wy_s3;
		end else if (num_ge) begin
			item.cs = ptsn_pkg::CASE_Q;
			item.bx = eqx_s3;
			item.by = eqy_s3;
		end else begin
			item.cs = ptsn_pkg::CASE_MID;
			item.bx = -wx_s3;
			item.by = -wy_s3;
		end
	end

	assign item_valid = v_s3;

endmodule

[src/ptsn_back.sv]
// ----------------------------------------------------------------------------
// ptsn_back
// Scales the direction by the projection ratio through a pipelined divider
// for interior points and forms the saturated offset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptsn_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ptsn_pkg::back_item_t    head,
	input  logic                    q_empty,
	output logic                    q_rd,
	output logic                    out_valid,
	output ptsn_pkg::out_item_t     out_item,
	input  logic                    out_full
);

	localparam int CB  = ptsn_pkg::CB;
	localparam int NW  = ptsn_pkg::NW;
	localparam int RW  = ptsn_pkg::RW;
	localparam int QB  = ptsn_pkg::QB;
	localparam int EW  = ptsn_pkg::EW;
	localparam int HIW = ptsn_pkg::HIW;

	logic en;
	logic v_b1, v_r, v_fin;
	ptsn_pkg::back_item_t it_b1;
	logic [2*CB-1:0]     plx_b1, ply_b1;
	logic [HIW+CB-1:0]   phx_b1, phy_b1;
	logic                div_v [0:QB];
	ptsn_pkg::div_t      div_s [0:QB];
	ptsn_pkg::div_t      dr_r;
	logic [CB:0]         qx_r, qy_r;
	logic signed [EW-1:0] vx, vy, sx_sum, sy_sum;

	// stall the whole back when the finished item cannot leave
	assign en   = !(v_fin && out_full);
	assign q_rd = en;

	// valid bits outside the divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b1  <= 1'b0;
			div_v[0] <= 1'b0;
			v_r   <= 1'b0;
			v_fin <= 1'b0;
		end else if (en) begin
			v_b1  <= !q_empty;
			div_v[0] <= v_b1;
			v_r   <= div_v[QB];
			v_fin <= v_r;
		end
	end

	// partial products of numerator and component magnitudes
	always_ff @(posedge clk) begin
		if (en) begin
			it_b1  <= head;
			plx_b1 <= head.num[CB-1:0] * head.mx;
			phx_b1 <= head.num[NW-1:CB] * head.mx;
			ply_b1 <= head.num[CB-1:0] * head.my;
			phy_b1 <= head.num[NW-1:CB] * head.my;
		end
	end

	// combine partial products into the dividends
	always_ff @(posedge clk) begin
		if (en) begin
			div_s[0].cs  <= it_b1.cs;
			div_s[0].bx  <= it_b1.bx;
			div_s[0].by  <= it_b1.by;
			div_s[0].den <= it_b1.den;
			div_s[0].sx  <= it_b1.sx;
			div_s[0].sy  <= it_b1.sy;
			div_s[0].rx  <= RW'(plx_b1) + (RW'(phx_b1) << CB);
			div_s[0].ry  <= RW'(ply_b1) + (RW'(phy_b1) << CB);
			div_s[0].qx  <= '0;
			div_s[0].qy  <= '0;
		end
	end

	// restoring divider, one quotient bit per stage, most significant first
	for (genvar j = 1; j <= QB; j++) begin : g_div
		localparam int K = QB - j;
		logic [RW-1:0]  dsh;
		logic           tx, ty;
		ptsn_pkg::div_t nxt;

		assign dsh = RW'(div_s[j-1].den) << K;
		assign tx  = (div_s[j-1].rx >= dsh);
		assign ty  = (div_s[j-1].ry >= dsh);

		// subtract where the shifted divisor fits and record the quotient bit
		always_comb begin
			nxt       = div_s[j-1];
			nxt.rx    = tx ? div_s[j-1].rx - dsh : div_s[j-1].rx;
			nxt.ry    = ty ? div_s[j-1].ry - dsh : div_s[j-1].ry;
			nxt.qx[K] = tx;
			nxt.qy[K] = ty;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_v[j] <= 1'b0;
			end else if (en) begin
				div_v[j] <= div_v[j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				div_s[j] <= nxt;
			end
		end
	end

	// round half away from zero on the remainder
	always_ff @(posedge clk) begin
		if (en) begin
			dr_r <= div_s[QB];
			qx_r <= (CB + 1)'(div_s[QB].qx)
				+ (CB + 1)'({div_s[QB].rx[NW-1:0], 1'b0} >= {1'b0, div_s[QB].den});
			qy_r <= (CB + 1)'(div_s[QB].qy)
				+ (CB + 1)'({div_s[QB].ry[NW-1:0], 1'b0} >= {1'b0, div_s[QB].den});
		end
	end

	// apply direction sign and, for interior points, add to the base offset
	assign vx = dr_r.sx ? -$signed({1'b0, qx_r}) : $signed({1'b0, qx_r});
	assign vy = dr_r.sy ? -$signed({1'b0, qy_r}) : $signed({1'b0, qy_r});
	assign sx_sum = (dr_r.cs == ptsn_pkg::CASE_MID) ? EW'(dr_r.bx) + vx : EW'(dr_r.bx);
	assign sy_sum = (dr_r.cs == ptsn_pkg::CASE_MID) ? EW'(dr_r.by) + vy : EW'(dr_r.by);

	// saturate into the final stage
	always_ff @(posedge clk) begin
		if (en) begin
			out_item.ex <= ptsn_pkg::sat_coord(sx_sum);
			out_item.ey <= ptsn_pkg::sat_coord(sy_sum);
			out_item.cs <= dr_r.cs;
		end
	end

	assign out_valid = v_fin;

endmodule

[src/point_to_segment_nearest_vector_core.sv]
// ----------------------------------------------------------------------------
// point_to_segment_nearest_vector_core
// Offset from a query point to the nearest point of a configured segment.
// ----------------------------------------------------------------------------
// Usage:
//   Write the segment ends P and Q through the cfg channel (index 0..3 for
//   p_x, p_y, q_x, q_y; cfg_ready is always high) while no item is in flight.
//   Push query points (x, y) when full is low. Results come out in order:
//   while empty is low, ex, ey and nearest_case show the oldest result, and
//   pop takes it. nearest_case is 0 for endpoint P or a point-sized segment,
//   1 for endpoint Q and 2 for an interior point.
//   Throughput is one item per cycle while pop keeps the result queue from
//   filling. A taken item passes three front stages, the classified item
//   queue, two multiply stages, a 32-stage restoring divider (one quotient
//   bit per stage), rounding, saturation and the result queue.
//   Reset clears the segment registers to zero and empties both queues.
//   When pop stays low the result queue fills, the back stalls, the middle
//   queue fills, the front stalls and full rises; nothing is dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "point_to_segment_nearest_vector_core_defines.svh"

module point_to_segment_nearest_vector_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [1:0]                        cfg_index,
	input  logic [ptsn_pkg::CB-1:0]           cfg_data,
	input  logic                              push,
	output logic                              full,
	input  logic signed [ptsn_pkg::CB-1:0]    x,
	input  logic signed [ptsn_pkg::CB-1:0]    y,
	output logic                              empty,
	input  logic                              pop,
	output logic signed [ptsn_pkg::CB-1:0]    ex,
	output logic signed [ptsn_pkg::CB-1:0]    ey,
	output logic [1:0]                        nearest_case
);

	logic signed [ptsn_pkg::CB-1:0] p_x_q, p_y_q, q_x_q, q_y_q;
	logic                   mid_valid, mid_full, mid_empty, mid_rd;
	ptsn_pkg::back_item_t   mid_item, mid_head;
	logic                   bk_valid, out_full, opush, opop;
	ptsn_pkg::out_item_t    bk_item, ohead;
	ptsn_pkg::out_item_t    omem_q [ptsn_pkg::QD];
	logic [ptsn_pkg::QAW-1:0] owp_q, orp_q;
	logic [ptsn_pkg::QAW:0]   ocnt_q;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_x_q <= '0;
			p_y_q <= '0;
			q_x_q <= '0;
			q_y_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				ptsn_pkg::REG_P_X: p_x_q <= cfg_data;
				ptsn_pkg::REG_P_Y: p_y_q <= cfg_data;
				ptsn_pkg::REG_Q_X: q_x_q <= cfg_data;
				ptsn_pkg::REG_Q_Y: q_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	ptsn_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.p_x        (p_x_q),
		.p_y        (p_y_q),
		.q_x        (q_x_q),
		.q_y        (q_y_q),
		.push       (push),
		.x          (x),
		.y          (y),
		.full       (full),
		.item_valid (mid_valid),
		.item       (mid_item),
		.item_full  (mid_full)
	);

	ptsn_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (mid_valid),
		.wr_item (mid_item),
		.full    (mid_full),
		.rd      (mid_rd),
		.head    (mid_head),
		.empty   (mid_empty)
	);

	ptsn_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (mid_head),
		.q_empty   (mid_empty),
		.q_rd      (mid_rd),
		.out_valid (bk_valid),
		.out_item  (bk_item),
		.out_full  (out_full)
	);

	// result queue
	assign out_full = (ocnt_q == (ptsn_pkg::QAW + 1)'(ptsn_pkg::QD));
	assign empty    = (ocnt_q == '0);
	assign opush    = bk_valid && !out_full;
	assign opop     = pop && !empty;
	assign ohead    = omem_q[orp_q];

	always_ff @(posedge clk) begin
		if (opush) begin
			omem_q[owp_q] <= bk_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owp_q  <= '0;
			orp_q  <= '0;
			ocnt_q <= '0;
		end else begin
			if (opush) begin
				owp_q <= owp_q + 1'b1;
			end
			if (opop) begin
				orp_q <= orp_q + 1'b1;
			end
			if (opush && !opop) begin
				ocnt_q <= ocnt_q + 1'b1;
			end else if (opop && !opush) begin
				ocnt_q <= ocnt_q - 1'b1;
			end
		end
	end

	assign ex           = ohead.ex;
	assign ey           = ohead.ey;
	assign nearest_case = ohead.cs;

	// checks
	`PTSN_ASSERT_SAME(a_ocnt_bound, 1'b1,
		ocnt_q <= (ptsn_pkg::QAW + 1)'(ptsn_pkg::QD), "result queue count overflow")
	`PTSN_ASSERT_NEXT(a_back_hold, bk_valid && out_full,
		bk_valid && $stable(bk_item), "back changed its item while stalled")
	`PTSN_ASSERT_NEXT(a_push_shows, opush && ocnt_q == '0,
		!empty, "pushed result not visible")

endmodule
